// ===== hw/rtl/mbb_pkg.sv =====
// Shared constants, operation codes, FSM state type and span mask helper for the blitter.
`timescale 1ns / 1ps

package mbb_pkg;

  localparam int ROWS          = 224;
  localparam int BYTES_PER_ROW = 32;
  localparam int STORE_SIZE    = ROWS * BYTES_PER_ROW;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  localparam int COL_W         = $clog2(BYTES_PER_ROW);
  // wide enough for (row + row offset) * BYTES_PER_ROW + col + byte offset
  localparam int SUM_W         = $clog2(1024 * BYTES_PER_ROW);

  localparam logic [2:0] OP_COPY  = 3'd0;
  localparam logic [2:0] OP_XOR   = 3'd1;
  localparam logic [2:0] OP_ERASE = 3'd2;
  localparam logic [2:0] OP_SPAN  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SPAN
  } state_t;

  // bits lo..hi of one byte
  function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
    return (8'hff << lo) & (8'hff >> (3'd7 - hi));
  endfunction

endpackage

// ===== hw/rtl/mbb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mono_bitmap_blitter.sv =====
// Top level of the one-bit-per-pixel blitter: command decode, offset walk and frame store RMW.
`timescale 1ns / 1ps

// Usage
// - Command channel: an item is taken at a rising edge with start high and busy low.
//   Fields: op, first, row, col, width, height, data, line_start, line_end.
// - Result channel: valid is high for exactly one cycle per item, carrying read_data,
//   collision, blit_done and error. There is no back-pressure; the consumer must take
//   each result in the cycle it is shown. All result fields read zero while valid is low.
// - Sprite ops (copy, xor, erase), read and unknown ops: the frame store is read at
//   the accept edge and the result appears (and, for sprite ops, the write-back happens)
//   in the following cycle. busy is high in that cycle, so no new item is taken before it.
// - A span op walks its bytes in the span state: the store read port fetches the
//   next byte while the write port stores the masked XOR of the current one. A span in
//   error goes to the execute state instead and writes nothing.
// - A span's result is shown with the write of its last byte.
// - Reset (rst, synchronous) clears the offsets and collision flag, then runs a clearing
//   pass over all ROWS * BYTES_PER_ROW = 7168 bytes of the frame store, one byte a cycle,
//   during which busy stays high and no item is taken.
// - The sprite rectangle walk (byte/row offsets, collision) lives in flops outside
//   the store; the store itself is a single simple dual-port RAM.

module mono_bitmap_blitter
  import mbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] op,
  input  logic       first,
  input  logic [7:0] row,
  input  logic [4:0] col,
  input  logic [5:0] width,
  input  logic [7:0] height,
  input  logic [7:0] data,
  input  logic [7:0] line_start,
  input  logic [7:0] line_end,
  output logic       valid,
  output logic [7:0] read_data,
  output logic       collision,
  output logic       blit_done,
  output logic       error
);

  // FSM and control state
  state_t             state, state_next;
  logic [ADDR_W-1:0]  clear_addr;
  logic [COL_W-1:0]   byte_offset;
  logic [7:0]         row_offset;
  logic               collision_seen;

  // per-item latched decode
  logic [2:0]         op_q;
  logic [7:0]         data_q;
  logic               err_q;
  logic               done_q;
  logic [ADDR_W-1:0]  span_base_q;
  logic [COL_W-1:0]   cur_b;
  logic [COL_W-1:0]   sb_q;
  logic [COL_W-1:0]   eb_q;
  logic [2:0]         lo_q;
  logic [2:0]         hi_q;
  // write-back address for sprite items: the address read at accept
  logic [ADDR_W-1:0]  rmw_addr_q;

  // frame store port
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  // command decode
  logic               accept;
  logic               is_sprite;
  logic [5:0]         w_eff;
  logic [7:0]         h_eff;
  logic [COL_W-1:0]   bo;
  logic [7:0]         ro;
  logic [SUM_W-1:0]   sprite_sum;
  logic               sprite_err;
  logic               col_end;
  logic               row_end;
  logic [SUM_W-1:0]   read_sum;
  logic               read_err;
  logic [4:0]         sb;
  logic [4:0]         eb;
  logic               span_err;
  logic [ADDR_W-1:0]  span_base;

  // execute-cycle helpers
  logic               xor_hit;
  logic               coll_now;
  logic               span_last;
  logic [2:0]         cur_lo;
  logic [2:0]         cur_hi;

  assign accept    = (state == ST_IDLE) && start;
  assign busy      = (state != ST_IDLE);
  assign is_sprite = (op == OP_COPY) || (op == OP_XOR) || (op == OP_ERASE);

  // sprite geometry: clamp width to [1, BYTES_PER_ROW], height zero acts as one
  always_comb begin
    w_eff = (width == 6'd0) ? 6'd1 : width;
    if (w_eff > 6'(BYTES_PER_ROW)) begin
      w_eff = 6'(BYTES_PER_ROW);
    end
    h_eff = (height == 8'd0) ? 8'd1 : height;
  end

  assign bo = first ? '0 : byte_offset;
  assign ro = first ? 8'd0 : row_offset;

  // linear address; a column past the row end spills into the next row
  assign sprite_sum = SUM_W'((SUM_W'(row) + SUM_W'(ro)) * SUM_W'(BYTES_PER_ROW))
                    + SUM_W'(col) + SUM_W'(bo);
  assign sprite_err = sprite_sum >= SUM_W'(STORE_SIZE);
  assign col_end    = (7'(bo) + 7'd1) >= 7'(w_eff);
  assign row_end    = (9'(ro) + 9'd1) >= 9'(h_eff);

  assign read_sum = SUM_W'(SUM_W'(row) * SUM_W'(BYTES_PER_ROW)) + SUM_W'(col);
  assign read_err = read_sum >= SUM_W'(STORE_SIZE);

  assign sb        = line_start[7:3];
  assign eb        = line_end[7:3];
  assign span_err  = (9'(row) >= 9'(ROWS)) || (line_end < line_start)
                   || (6'(eb) >= 6'(BYTES_PER_ROW));
  assign span_base = ADDR_W'(SUM_W'(row) * SUM_W'(BYTES_PER_ROW));

  // xor collision picks up the byte being written back this cycle
  assign xor_hit  = (op_q == OP_XOR) && !err_q && ((ram_rdata ^ data_q) != 8'd0);
  assign coll_now = collision_seen | xor_hit;

  assign span_last = (cur_b == eb_q);
  assign cur_lo    = (cur_b == sb_q) ? lo_q : 3'd0;
  assign cur_hi    = span_last ? hi_q : 3'd7;

  // ---------------------------------------------------------------------------
  // State register and control flops
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clear_addr     <= '0;
      byte_offset    <= '0;
      row_offset     <= 8'd0;
      collision_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
      // offsets advance at accept, independent of the store contents
      if (accept && is_sprite) begin
        if (first) begin
          collision_seen <= 1'b0;
        end
        if (col_end) begin
          byte_offset <= '0;
          row_offset  <= row_end ? 8'd0 : (ro + 8'd1);
        end else begin
          byte_offset <= COL_W'(7'(bo) + 7'd1);
          row_offset  <= ro;
        end
      end
      // collision needs the read data, so it settles in the execute cycle
      if ((state == ST_EXEC) &&
          ((op_q == OP_COPY) || (op_q == OP_XOR) || (op_q == OP_ERASE))) begin
        collision_seen <= done_q ? 1'b0 : coll_now;
      end
    end
  end

  // item payload latched at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q        <= op;
      data_q      <= data;
      span_base_q <= span_base;
      cur_b       <= COL_W'(sb);
      sb_q        <= COL_W'(sb);
      eb_q        <= COL_W'(eb);
      lo_q        <= line_start[2:0];
      hi_q        <= line_end[2:0];
      if (is_sprite) begin
        err_q  <= sprite_err;
        done_q <= col_end && row_end;
      end else if (op == OP_SPAN) begin
        err_q  <= span_err;
        done_q <= 1'b1;
      end else if (op == OP_READ) begin
        err_q  <= read_err;
        done_q <= 1'b0;
      end else begin
        err_q  <= 1'b0;
        done_q <= 1'b0;
      end
    end else if ((state == ST_SPAN) && !span_last) begin
      cur_b <= cur_b + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rmw_addr_q <= sprite_err ? '0 : sprite_sum[ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == ADDR_W'(STORE_SIZE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ((op == OP_SPAN) && !span_err) ? ST_SPAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      ST_SPAN: begin
        if (span_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs and store port
  // ---------------------------------------------------------------------------
  always_comb begin
    valid     = 1'b0;
    read_data = 8'd0;
    collision = 1'b0;
    blit_done = 1'b0;
    error     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 8'd0;
    ram_raddr = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
      end
      ST_IDLE: begin
        // fetch the target byte so it is on the read port in the next cycle
        if (is_sprite) begin
          ram_raddr = sprite_err ? '0 : sprite_sum[ADDR_W-1:0];
        end else if (op == OP_READ) begin
          ram_raddr = read_err ? '0 : read_sum[ADDR_W-1:0];
        end else if (op == OP_SPAN) begin
          ram_raddr = span_err ? '0 : (span_base + ADDR_W'(sb));
        end
      end
      ST_EXEC: begin
        valid     = 1'b1;
        blit_done = done_q;
        error     = err_q;
        if ((op_q == OP_READ) && !err_q) begin
          read_data = ram_rdata;
        end
        if ((op_q == OP_XOR) && done_q) begin
          collision = coll_now;
        end
        if (!err_q) begin
          ram_waddr = rmw_addr_q;
        end
        if (((op_q == OP_COPY) || (op_q == OP_XOR) || (op_q == OP_ERASE)) && !err_q) begin
          ram_we = 1'b1;
          case (op_q)
            OP_COPY: ram_wdata = data_q;
            OP_XOR:  ram_wdata = ram_rdata ^ data_q;
            default: ram_wdata = 8'd0;
          endcase
        end
      end
      ST_SPAN: begin
        ram_we    = 1'b1;
        ram_waddr = span_base_q + ADDR_W'(cur_b);
        ram_wdata = ram_rdata ^ span_mask(cur_lo, cur_hi);
        if (span_last) begin
          valid     = 1'b1;
          blit_done = 1'b1;
        end else begin
          ram_raddr = span_base_q + ADDR_W'(cur_b) + ADDR_W'(1);
        end
      end
      default: begin
        valid = 1'b0;
      end
    endcase
  end

  mbb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a result only ever comes out of a working cycle
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy)
    else $error("result strobe outside a working cycle");

  // every accepted item occupies the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !$past(busy)))
    else $error("accepted item did not occupy the block");

  // a nonzero read byte belongs to a good read result
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (read_data != 8'd0) |-> (valid && !error && !blit_done))
    else $error("read data outside a good read result");

  // no store write lands on the cycle an item is accepted
  a_no_write_at_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !ram_we)
    else $error("store write in idle cycle");

endmodule
